>>> design/bptc_pkg.sv
`default_nettype none

package bptc_pkg;

    // Number of register stages from the input beat to the output register.
    localparam int NUM_STAGES = 10;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Field widths.
    localparam int RAW_W  = 24;
    localparam int TEMP_W = 20;
    localparam int PRES_W = 20;
    localparam int STAT_W = 2;

    // Calibration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS     = 3'd0,
        CFG_OFF      = 3'd1,
        CFG_TCS      = 3'd2,
        CFG_TCO      = 3'd3,
        CFG_TREF     = 3'd4,
        CFG_TEMPSENS = 3'd5
    } t_cfg_idx;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_RAW_ZERO  = 2'd1,
        STAT_LOW_PRES  = 2'd2,
        STAT_SATURATED = 2'd3
    } t_status;

    // Temperature thresholds in hundredths of a degree.
    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_COLD = -20'sd1500;

    // Pressure limits in pascals.
    localparam logic signed [47:0] PRES_LOW = 48'sd50000;
    localparam logic signed [47:0] PRES_MAX = 48'sd1048575;

endpackage : bptc_pkg

`default_nettype wire

>>> design/baro_pressure_temp_compensation.sv
// Barometer reading compensation with second-order temperature correction.
//
// Input channel: one beat carries a raw pressure and a raw temperature
// conversion (24 bits each), accepted when i_valid and o_ready are both high.
// Output channel: one beat per input beat with the temperature in 0.01 C,
// the pressure in Pa and a status code, taken when o_valid and i_ready are high.
// The user must write the six calibration words (i_cfg_we / i_cfg_idx /
// i_cfg_wdata) only while no beat is in flight; the block does not enforce it.
//
// Throughput is one beat per cycle while the receiver keeps i_ready high.
// The datapath is ten register stages deep, set by the multiplier chain
// (first-order products, squares, and the split raw-pressure by sensitivity
// product) with a register after each multiply; the last stage is the output
// register. Reset (synchronous, active low) empties every stage and clears the
// calibration words to zero. When the receiver stalls, each stage holds its
// beat and a stage upstream keeps filling as long as it has a free slot, so up
// to ten beats are absorbed before o_ready drops; nothing is lost or repeated.

`default_nettype none

module baro_pressure_temp_compensation (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Calibration write port.
    input  wire logic                                   i_cfg_we,
    input  wire logic [bptc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [bptc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    // Input channel.
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [bptc_pkg::RAW_W-1:0]             i_raw_pressure,
    input  wire logic [bptc_pkg::RAW_W-1:0]             i_raw_temperature,
    // Output channel.
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic signed [bptc_pkg::TEMP_W-1:0]          o_temperature_centi,
    output logic [bptc_pkg::PRES_W-1:0]                 o_pressure_pa,
    output logic [bptc_pkg::STAT_W-1:0]                 o_status
);

    import bptc_pkg::*;

    // Calibration words.
    logic [15:0] r_coef_sens, r_coef_off, r_coef_tcs;
    logic [15:0] r_coef_tco, r_coef_tref, r_coef_tempsens;

    // Stage valid bits and stage load enables.
    logic [NUM_STAGES:1] r_vld;
    logic [NUM_STAGES:1] w_en;

    // Stage 1: temperature difference.
    logic [RAW_W-1:0]   r_d1_s1;
    logic signed [24:0] r_dt_s1;
    logic               r_zero_s1;
    logic signed [24:0] n_dt;

    // Stage 2: first-order products.
    logic signed [41:0] r_p6_s2, r_p4_s2, r_p3_s2;
    logic signed [49:0] r_pdd_s2;
    logic [RAW_W-1:0]   r_d1_s2;
    logic               r_zero_s2;
    logic signed [41:0] n_p6, n_p4, n_p3;
    logic signed [49:0] n_pdd;

    // Stage 3: first-order temperature, offset and sensitivity.
    logic signed [TEMP_W-1:0] r_temp1_s3;
    logic signed [39:0]       r_off1_s3, r_sens1_s3;
    logic [17:0]              r_t2_s3;
    logic [RAW_W-1:0]         r_d1_s3;
    logic                     r_zero_s3;
    logic signed [41:0]       w_p6b, w_p4b, w_p3b, w_q6, w_q4, w_q3;
    logic signed [TEMP_W-1:0] n_temp1;
    logic signed [39:0]       n_off1, n_sens1;

    // Stage 4: squares for the low-temperature correction.
    logic [35:0]              r_aa_s4, r_bb_s4;
    logic                     r_lt2000_s4, r_lt1500_s4;
    logic signed [TEMP_W-1:0] r_temp1_s4;
    logic signed [39:0]       r_off1_s4, r_sens1_s4;
    logic [17:0]              r_t2_s4;
    logic [RAW_W-1:0]         r_d1_s4;
    logic                     r_zero_s4;
    logic signed [20:0]       w_a, w_b;
    logic signed [41:0]       w_asq, w_bsq;

    // Stage 5: second-order offset and sensitivity terms.
    logic [39:0]              r_off2_s5, r_sens2_s5;
    logic                     r_lt2000_s5;
    logic signed [TEMP_W-1:0] r_temp1_s5;
    logic signed [39:0]       r_off1_s5, r_sens1_s5;
    logic [17:0]              r_t2_s5;
    logic [RAW_W-1:0]         r_d1_s5;
    logic                     r_zero_s5;
    logic [39:0]              w_aa, w_bb, w_5aa, w_7bb, w_11bb;
    logic [39:0]              n_off2, n_sens2;

    // Stage 6: corrected temperature, offset and sensitivity.
    logic signed [TEMP_W-1:0] r_temp_s6;
    logic signed [39:0]       r_off_s6, r_sens_s6;
    logic [RAW_W-1:0]         r_d1_s6;
    logic                     r_zero_s6;
    logic signed [TEMP_W-1:0] n_temp;
    logic signed [39:0]       n_off, n_sens;

    // Stage 7: partial products of raw pressure by sensitivity.
    logic [43:0]              r_pl_s7;
    logic signed [44:0]       r_ph_s7;
    logic signed [39:0]       r_off_s7;
    logic signed [TEMP_W-1:0] r_temp_s7;
    logic                     r_zero_s7;
    logic [43:0]              n_pl;
    logic signed [44:0]       n_ph;

    // Stage 8: full product.
    logic signed [63:0]       r_prod_s8;
    logic signed [39:0]       r_off_s8;
    logic signed [TEMP_W-1:0] r_temp_s8;
    logic                     r_zero_s8;
    logic signed [63:0]       w_phx, n_prod;

    // Stage 9: scaled product minus offset.
    logic signed [47:0]       r_x_s9;
    logic signed [TEMP_W-1:0] r_temp_s9;
    logic                     r_zero_s9;
    logic signed [63:0]       w_prodb, w_q;
    logic signed [47:0]       n_x;

    // Stage 10: output register.
    logic signed [TEMP_W-1:0] r_temp_out;
    logic [PRES_W-1:0]        r_pres_out;
    t_status                  r_status_out;
    logic signed [47:0]       w_xb, w_p;
    logic signed [TEMP_W-1:0] n_temp_out;
    logic [PRES_W-1:0]        n_pres_out;
    t_status                  n_status_out;

    // Calibration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_sens     <= '0;
            r_coef_off      <= '0;
            r_coef_tcs      <= '0;
            r_coef_tco      <= '0;
            r_coef_tref     <= '0;
            r_coef_tempsens <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SENS:     r_coef_sens     <= i_cfg_wdata;
                CFG_OFF:      r_coef_off      <= i_cfg_wdata;
                CFG_TCS:      r_coef_tcs      <= i_cfg_wdata;
                CFG_TCO:      r_coef_tco      <= i_cfg_wdata;
                CFG_TREF:     r_coef_tref     <= i_cfg_wdata;
                CFG_TEMPSENS: r_coef_tempsens <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it loads.
    always_comb begin
        w_en[NUM_STAGES] = !r_vld[NUM_STAGES] || i_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_en[1];
    assign o_valid = r_vld[NUM_STAGES];

    // Stage 1 logic: dT = D2 - C5 * 256.
    assign n_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, r_coef_tref, 8'h00});

    // Stage 2 logic: products with dT.
    assign n_p6  = r_dt_s1 * $signed({1'b0, r_coef_tempsens});
    assign n_p4  = r_dt_s1 * $signed({1'b0, r_coef_tco});
    assign n_p3  = r_dt_s1 * $signed({1'b0, r_coef_tcs});
    assign n_pdd = r_dt_s1 * r_dt_s1;

    // Stage 3 logic: divisions rounding toward zero, then first-order sums.
    assign w_p6b   = r_p6_s2 + (r_p6_s2[41] ? 42'sd8388607 : 42'sd0);
    assign w_p4b   = r_p4_s2 + (r_p4_s2[41] ? 42'sd127 : 42'sd0);
    assign w_p3b   = r_p3_s2 + (r_p3_s2[41] ? 42'sd255 : 42'sd0);
    assign w_q6    = w_p6b >>> 23;
    assign w_q4    = w_p4b >>> 7;
    assign w_q3    = w_p3b >>> 8;
    assign n_temp1 = TEMP_REF + w_q6[TEMP_W-1:0];
    assign n_off1  = $signed({8'd0, r_coef_off, 16'd0}) + w_q4[39:0];
    assign n_sens1 = $signed({9'd0, r_coef_sens, 15'd0}) + w_q3[39:0];

    // Stage 4 logic: distances from the two thresholds, squared.
    assign w_a   = $signed({r_temp1_s3[TEMP_W-1], r_temp1_s3}) - 21'sd2000;
    assign w_b   = $signed({r_temp1_s3[TEMP_W-1], r_temp1_s3}) + 21'sd1500;
    assign w_asq = w_a * w_a;
    assign w_bsq = w_b * w_b;

    // Stage 5 logic: constant multiples by shift and add; all terms are
    // nonnegative, so truncating division is a plain shift.
    assign w_aa    = {4'd0, r_aa_s4};
    assign w_bb    = {4'd0, r_bb_s4};
    assign w_5aa   = (w_aa << 2) + w_aa;
    assign w_7bb   = (w_bb << 3) - w_bb;
    assign w_11bb  = (w_bb << 3) + (w_bb << 1) + w_bb;
    assign n_off2  = (w_5aa >> 1) + (r_lt1500_s4 ? w_7bb : 40'd0);
    assign n_sens2 = (w_5aa >> 2) + (r_lt1500_s4 ? (w_11bb >> 1) : 40'd0);

    // Stage 6 logic: apply the correction only below 20 C.
    assign n_temp = r_lt2000_s5 ? (r_temp1_s5 - $signed({2'b00, r_t2_s5})) : r_temp1_s5;
    assign n_off  = r_lt2000_s5 ? (r_off1_s5 - $signed(r_off2_s5)) : r_off1_s5;
    assign n_sens = r_lt2000_s5 ? (r_sens1_s5 - $signed(r_sens2_s5)) : r_sens1_s5;

    // Stage 7 logic: D1 * SENS split at bit 20 into two narrower products.
    assign n_pl = r_d1_s6 * r_sens_s6[19:0];
    assign n_ph = $signed({1'b0, r_d1_s6}) * $signed(r_sens_s6[39:20]);

    // Stage 8 logic: recombine the partial products.
    assign w_phx  = {{19{r_ph_s7[44]}}, r_ph_s7};
    assign n_prod = (w_phx <<< 20) + $signed({20'd0, r_pl_s7});

    // Stage 9 logic: divide by 2^21 toward zero and remove the offset.
    assign w_prodb = r_prod_s8 + (r_prod_s8[63] ? 64'sd2097151 : 64'sd0);
    assign w_q     = w_prodb >>> 21;
    assign n_x     = w_q[47:0] - $signed({{8{r_off_s8[39]}}, r_off_s8});

    // Stage 10 logic: divide by 2^15 toward zero, clamp and classify.
    assign w_xb = r_x_s9 + (r_x_s9[47] ? 48'sd32767 : 48'sd0);
    assign w_p  = w_xb >>> 15;

    always_comb begin
        n_temp_out   = r_temp_s9;
        n_pres_out   = w_p[PRES_W-1:0];
        n_status_out = STAT_OK;
        if (r_zero_s9) begin
            n_temp_out   = '0;
            n_pres_out   = '0;
            n_status_out = STAT_RAW_ZERO;
        end else begin
            if (w_p < PRES_LOW) begin
                n_status_out = STAT_LOW_PRES;
            end
            priority if (w_p < 48'sd0) begin
                n_pres_out = '0;
            end else if (w_p > PRES_MAX) begin
                n_pres_out   = '1;
                n_status_out = STAT_SATURATED;
            end else begin
                n_pres_out = w_p[PRES_W-1:0];
            end
        end
    end

    // Datapath registers; each stage loads on its enable.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_d1_s1   <= i_raw_pressure;
            r_dt_s1   <= n_dt;
            r_zero_s1 <= (i_raw_pressure == '0) || (i_raw_temperature == '0);
        end
        if (w_en[2]) begin
            r_p6_s2   <= n_p6;
            r_p4_s2   <= n_p4;
            r_p3_s2   <= n_p3;
            r_pdd_s2  <= n_pdd;
            r_d1_s2   <= r_d1_s1;
            r_zero_s2 <= r_zero_s1;
        end
        if (w_en[3]) begin
            r_temp1_s3 <= n_temp1;
            r_off1_s3  <= n_off1;
            r_sens1_s3 <= n_sens1;
            r_t2_s3    <= r_pdd_s2[48:31];
            r_d1_s3    <= r_d1_s2;
            r_zero_s3  <= r_zero_s2;
        end
        if (w_en[4]) begin
            r_aa_s4     <= w_asq[35:0];
            r_bb_s4     <= w_bsq[35:0];
            r_lt2000_s4 <= r_temp1_s3 < TEMP_REF;
            r_lt1500_s4 <= r_temp1_s3 < TEMP_COLD;
            r_temp1_s4  <= r_temp1_s3;
            r_off1_s4   <= r_off1_s3;
            r_sens1_s4  <= r_sens1_s3;
            r_t2_s4     <= r_t2_s3;
            r_d1_s4     <= r_d1_s3;
            r_zero_s4   <= r_zero_s3;
        end
        if (w_en[5]) begin
            r_off2_s5   <= n_off2;
            r_sens2_s5  <= n_sens2;
            r_lt2000_s5 <= r_lt2000_s4;
            r_temp1_s5  <= r_temp1_s4;
            r_off1_s5   <= r_off1_s4;
            r_sens1_s5  <= r_sens1_s4;
            r_t2_s5     <= r_t2_s4;
            r_d1_s5     <= r_d1_s4;
            r_zero_s5   <= r_zero_s4;
        end
        if (w_en[6]) begin
            r_temp_s6 <= n_temp;
            r_off_s6  <= n_off;
            r_sens_s6 <= n_sens;
            r_d1_s6   <= r_d1_s5;
            r_zero_s6 <= r_zero_s5;
        end
        if (w_en[7]) begin
            r_pl_s7   <= n_pl;
            r_ph_s7   <= n_ph;
            r_off_s7  <= r_off_s6;
            r_temp_s7 <= r_temp_s6;
            r_zero_s7 <= r_zero_s6;
        end
        if (w_en[8]) begin
            r_prod_s8 <= n_prod;
            r_off_s8  <= r_off_s7;
            r_temp_s8 <= r_temp_s7;
            r_zero_s8 <= r_zero_s7;
        end
        if (w_en[9]) begin
            r_x_s9    <= n_x;
            r_temp_s9 <= r_temp_s8;
            r_zero_s9 <= r_zero_s8;
        end
        if (w_en[10]) begin
            r_temp_out   <= n_temp_out;
            r_pres_out   <= n_pres_out;
            r_status_out <= n_status_out;
        end
    end

    assign o_temperature_centi = r_temp_out;
    assign o_pressure_pa       = r_pres_out;
    assign o_status            = r_status_out;

endmodule : baro_pressure_temp_compensation

`default_nettype wire

>>> tb/baro_pressure_temp_compensation_test.sv
`timescale 1ns / 100ps

module baro_pressure_temp_compensation_test;
    import bptc_pkg::*;

    // Divisors and scale factors of the compensation arithmetic.
    localparam longint TEMP_SLOPE_DIV = 64'sd8388608;
    localparam longint T2_DIV         = 64'sd2147483648;
    localparam longint OFF_SCALE      = 64'sd65536;
    localparam longint SENS_SCALE     = 64'sd32768;
    localparam longint OFF_SLOPE_DIV  = 64'sd128;
    localparam longint SENS_SLOPE_DIV = 64'sd256;
    localparam longint PRODUCT_DIV    = 64'sd2097152;
    localparam longint PRES_DIV       = 64'sd32768;

    // A typical factory calibration and a matching raw reading pair.
    localparam logic [CFG_DATA_W-1:0] CAL_SENS     = 16'd40127;
    localparam logic [CFG_DATA_W-1:0] CAL_OFF      = 16'd36924;
    localparam logic [CFG_DATA_W-1:0] CAL_TCS      = 16'd23317;
    localparam logic [CFG_DATA_W-1:0] CAL_TCO      = 16'd23282;
    localparam logic [CFG_DATA_W-1:0] CAL_TREF     = 16'd33464;
    localparam logic [CFG_DATA_W-1:0] CAL_TEMPSENS = 16'd28312;
    localparam logic [CFG_DATA_W-1:0] CAL_MAX      = 16'hFFFF;
    localparam logic [RAW_W-1:0]      TYP_D1       = 24'd9085466;
    localparam logic [RAW_W-1:0]      TYP_D2       = 24'd8569150;
    localparam logic [RAW_W-1:0]      RAW_MAX      = 24'hFFFFFF;

    typedef struct packed {
        logic [TEMP_W-1:0] temperature_centi;
        logic [PRES_W-1:0] pressure_pa;
        t_status           status;
    } t_reading;

    // Scoreboard: keeps its own calibration copy and the queue of
    // compensated readings still owed by the block.
    class compensation_predictor;
        logic [CFG_DATA_W-1:0] coef [6];
        t_reading              expected_readings [$];
        int unsigned           mismatches;

        function new();
            foreach (coef[i]) begin
                coef[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void set_coef(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            coef[idx] = value;
        endfunction

        // Compensate one raw pair with 64-bit signed arithmetic.
        function t_reading compensate(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
            longint   d1, d2, dt, temp, off, sens, off2, sens2, a, b, p;
            t_reading r;
            d1 = longint'(raw_p);
            d2 = longint'(raw_t);
            if (d1 == 0 || d2 == 0) begin
                r.temperature_centi = '0;
                r.pressure_pa       = '0;
                r.status            = STAT_RAW_ZERO;
                return r;
            end
            dt   = d2 - longint'(coef[CFG_TREF]) * 256;
            temp = TEMP_REF + dt * longint'(coef[CFG_TEMPSENS]) / TEMP_SLOPE_DIV;
            off  = longint'(coef[CFG_OFF]) * OFF_SCALE
                   + dt * longint'(coef[CFG_TCO]) / OFF_SLOPE_DIV;
            sens = longint'(coef[CFG_SENS]) * SENS_SCALE
                   + dt * longint'(coef[CFG_TCS]) / SENS_SLOPE_DIV;

            // Second-order correction below 20 C, with an extra term below -15 C.
            if (temp < TEMP_REF) begin
                a     = temp - TEMP_REF;
                b     = temp - TEMP_COLD;
                off2  = 5 * (a * a) / 2;
                sens2 = 5 * (a * a) / 4;
                if (temp < TEMP_COLD) begin
                    off2  += 7 * (b * b);
                    sens2 += 11 * (b * b) / 2;
                end
                temp -= dt * dt / T2_DIV;
                off  -= off2;
                sens -= sens2;
            end

            p = (d1 * sens / PRODUCT_DIV - off) / PRES_DIV;

            // Status and clamping of the pressure.
            if (p < PRES_LOW) begin
                r.status = STAT_LOW_PRES;
            end else begin
                r.status = STAT_OK;
            end
            if (p < 0) begin
                r.pressure_pa = '0;
            end else if (p > PRES_MAX) begin
                r.pressure_pa = PRES_MAX[PRES_W-1:0];
                r.status      = STAT_SATURATED;
            end else begin
                r.pressure_pa = p[PRES_W-1:0];
            end
            r.temperature_centi = temp[TEMP_W-1:0];
            return r;
        endfunction

        function void note_reading(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
            expected_readings.push_back(compensate(raw_p, raw_t));
        endfunction

        function void check_result(logic [TEMP_W-1:0] temp_centi,
                                   logic [PRES_W-1:0] pres_pa,
                                   logic [STAT_W-1:0] stat);
            t_reading want;
            if (expected_readings.size() == 0) begin
                $error("result beat with no reading pending: temp %0d pressure %0d status %0d",
                       $signed(temp_centi), pres_pa, stat);
                mismatches++;
                return;
            end
            want = expected_readings.pop_front();
            if (temp_centi !== want.temperature_centi) begin
                $error("temperature_centi: expected %0d, actual %0d",
                       $signed(want.temperature_centi), $signed(temp_centi));
                mismatches++;
            end
            if (pres_pa !== want.pressure_pa) begin
                $error("pressure_pa: expected %0d, actual %0d", want.pressure_pa, pres_pa);
                mismatches++;
            end
            if (stat !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, stat);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata;
    logic                        i_valid;
    logic                        o_ready;
    logic [RAW_W-1:0]            i_raw_pressure;
    logic [RAW_W-1:0]            i_raw_temperature;
    logic                        o_valid;
    logic                        i_ready;
    logic signed [TEMP_W-1:0]    o_temperature_centi;
    logic [PRES_W-1:0]           o_pressure_pa;
    logic [STAT_W-1:0]           o_status;

    // When set, neither side inserts idle cycles.
    bit                          steady;
    compensation_predictor       comp_check = new();

    baro_pressure_temp_compensation dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_pa       (o_pressure_pa),
        .o_status            (o_status)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Write one calibration word; the write enable is left high for the caller.
    task automatic write_coef(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        comp_check.set_coef(idx, value);
    endtask

    task automatic load_calibration(input logic [CFG_DATA_W-1:0] sens, off, tcs, tco,
                                    tref, tempsens);
        write_coef(CFG_SENS, sens);
        write_coef(CFG_OFF, off);
        write_coef(CFG_TCS, tcs);
        write_coef(CFG_TCO, tco);
        write_coef(CFG_TREF, tref);
        write_coef(CFG_TEMPSENS, tempsens);
        i_cfg_we <= 1'b0;
    endtask

    // Send one reading pair after a random gap (none if steady); wait for its beat.
    task automatic send_reading(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_raw_pressure    <= raw_p;
        i_raw_temperature <= raw_t;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        comp_check.note_reading(raw_p, raw_t);
    endtask

    // Mostly plausible readings when the calibration is realistic; otherwise
    // full-range values, with an occasional zero conversion.
    task automatic send_random_reading(input bit realistic);
        logic [RAW_W-1:0] raw_p, raw_t;
        int               pick;
        pick  = $urandom_range(0, 9);
        raw_p = RAW_W'($urandom);
        raw_t = RAW_W'($urandom);
        if (pick == 0) begin
            case ($urandom_range(0, 2))
                0:       raw_p = '0;
                1:       raw_t = '0;
                default: begin
                    raw_p = '0;
                    raw_t = '0;
                end
            endcase
        end else if (realistic && pick >= 4) begin
            raw_p = RAW_W'($urandom_range(5000000, 11000000));
            raw_t = RAW_W'($urandom_range(6000000, 10000000));
        end
        send_reading(raw_p, raw_t);
    endtask

    // Drop valid and wait until every owed result is back and the pipe is empty.
    task automatic settle();
        i_valid <= 1'b0;
        while (comp_check.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (NUM_STAGES + 2) @(posedge i_clk);
    endtask

    // Result side: random stall before each beat unless steady, then check it.
    initial begin
        int stall;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            stall = steady ? 0 : $urandom_range(0, 19);
            repeat (stall) begin
                i_ready <= 1'b0;
                @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) begin
                @(posedge i_clk);
            end
            comp_check.check_result(o_temperature_centi, o_pressure_pa, o_status);
        end
    end

    // Stimulus.
    initial begin
        int n;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_SENS;
        i_cfg_wdata       <= '0;
        i_valid           <= 1'b0;
        i_raw_pressure    <= '0;
        i_raw_temperature <= '0;
        steady            = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Calibration still at its cleared value.
        send_reading(TYP_D1, TYP_D2);
        send_reading(RAW_MAX, 24'd1);
        settle();

        // Typical calibration: zero conversions, normal, cold, very cold,
        // low and negative pressure, extremes of the raw fields.
        load_calibration(CAL_SENS, CAL_OFF, CAL_TCS, CAL_TCO, CAL_TREF, CAL_TEMPSENS);
        send_reading('0, TYP_D2);
        send_reading(TYP_D1, '0);
        send_reading('0, '0);
        send_reading(TYP_D1, TYP_D2);
        send_reading(TYP_D1, 24'd8000000);
        send_reading(TYP_D1, 24'd7000000);
        send_reading(TYP_D1, 24'd1);
        send_reading(24'd4000000, TYP_D2);
        send_reading(24'd1, TYP_D2);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(24'd1, 24'd1);
        settle();

        // High sensitivity with no offset drives the pressure into saturation.
        load_calibration(CAL_MAX, '0, CAL_MAX, '0, '0, '0);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(RAW_MAX, 24'd1);
        send_reading(24'd1, RAW_MAX);
        send_reading(24'd8000000, 24'd8000000);
        settle();

        // Random phases over several calibrations.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0, 3: load_calibration(CAL_SENS, CAL_OFF, CAL_TCS, CAL_TCO, CAL_TREF,
                                       CAL_TEMPSENS);
                1:    load_calibration(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
                2:    load_calibration(CAL_MAX, '0, CAL_MAX, '0, '0, '0);
                default: load_calibration(CFG_DATA_W'($urandom_range(0, 65535)),
                                          CFG_DATA_W'($urandom_range(0, 65535)),
                                          CFG_DATA_W'($urandom_range(0, 65535)),
                                          CFG_DATA_W'($urandom_range(0, 65535)),
                                          CFG_DATA_W'($urandom_range(0, 65535)),
                                          CFG_DATA_W'($urandom_range(0, 65535)));
            endcase
            steady = (phase == 3);
            n = $urandom_range(200, 250);
            repeat (n) send_random_reading(phase == 0 || phase == 3);
            settle();
            steady = 1'b0;
        end

        if (comp_check.mismatches == 0 && comp_check.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
